// ===== rtl/core/pipeline_execute_stage_defines.svh =====
// Assertion macros for the execute stage.
`ifndef PIPELINE_EXECUTE_STAGE_DEFINES_SVH
`define PIPELINE_EXECUTE_STAGE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PES_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PES_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pes_pkg.sv =====
`default_nettype none

package pes_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned PcW     = 31;
    localparam int unsigned OpW     = 5;
    localparam int unsigned DivCntW = 5;
    localparam int unsigned ShamtW  = 5;

    localparam logic [OpW-1:0] OP_NOP  = 5'd0;
    localparam logic [OpW-1:0] OP_ADD  = 5'd1;
    localparam logic [OpW-1:0] OP_MUL  = 5'd2;
    localparam logic [OpW-1:0] OP_SUB  = 5'd3;
    localparam logic [OpW-1:0] OP_DIV  = 5'd4;
    localparam logic [OpW-1:0] OP_LSH  = 5'd5;
    localparam logic [OpW-1:0] OP_RSH  = 5'd6;
    localparam logic [OpW-1:0] OP_AND  = 5'd7;
    localparam logic [OpW-1:0] OP_OR   = 5'd8;
    localparam logic [OpW-1:0] OP_XOR  = 5'd9;
    localparam logic [OpW-1:0] OP_LD   = 5'd10;
    localparam logic [OpW-1:0] OP_LDC  = 5'd11;
    localparam logic [OpW-1:0] OP_ST   = 5'd12;
    localparam logic [OpW-1:0] OP_STC  = 5'd13;
    localparam logic [OpW-1:0] OP_BLT  = 5'd14;
    localparam logic [OpW-1:0] OP_BNZ  = 5'd15;
    localparam logic [OpW-1:0] OP_B    = 5'd16;
    localparam logic [OpW-1:0] OP_J    = 5'd17;
    localparam logic [OpW-1:0] OP_JLT  = 5'd18;
    localparam logic [OpW-1:0] OP_JNZ  = 5'd19;
    localparam logic [OpW-1:0] OP_CMP  = 5'd20;
    localparam logic [OpW-1:0] OP_HALT = 5'd21;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_state;

    typedef struct packed {
        logic load_out;
        logic sel_div;
        logic squash;
        logic div_start;
    } t_dp_cmd;

    typedef struct packed {
        logic take;
        logic is_div;
        logic div_done;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/pes_div.sv =====
`default_nettype none

module pes_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [pes_pkg::DataW-1:0]    i_dividend,
    input  wire logic signed [pes_pkg::DataW-1:0]    i_divisor,
    output logic                                     o_done,
    output logic signed [pes_pkg::DataW-1:0]         o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [pes_pkg::DivCntW-1:0]     r_cnt;
    logic [pes_pkg::DataW-1:0]       r_quo;
    logic [pes_pkg::DataW-1:0]       r_rem;
    logic [pes_pkg::DataW-1:0]       r_dvs;
    logic                            r_neg;
    logic                            r_zero;

    logic [pes_pkg::DataW-1:0]       w_a_mag;
    logic [pes_pkg::DataW-1:0]       w_b_mag;
    logic [pes_pkg::DataW:0]         w_shifted;
    logic [pes_pkg::DataW:0]         w_diff;

    assign w_a_mag   = i_dividend[pes_pkg::DataW-1] ? -i_dividend : i_dividend;
    assign w_b_mag   = i_divisor[pes_pkg::DataW-1]  ? -i_divisor  : i_divisor;
    assign w_shifted = {r_rem, r_quo[pes_pkg::DataW-1]};
    assign w_diff    = w_shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {pes_pkg::DivCntW{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring divide on magnitudes, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= w_a_mag;
            r_rem  <= '0;
            r_dvs  <= w_b_mag;
            r_neg  <= i_dividend[pes_pkg::DataW-1] ^ i_divisor[pes_pkg::DataW-1];
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            if (!w_diff[pes_pkg::DataW]) begin
                r_rem <= w_diff[pes_pkg::DataW-1:0];
                r_quo <= {r_quo[pes_pkg::DataW-2:0], 1'b1};
            end else begin
                r_rem <= w_shifted[pes_pkg::DataW-1:0];
                r_quo <= {r_quo[pes_pkg::DataW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_zero ? '0 : (r_neg ? $signed(-r_quo) : $signed(r_quo));

endmodule

`default_nettype wire

// ===== rtl/core/pes_dp.sv =====
`default_nettype none

module pes_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pes_pkg::t_dp_cmd                    i_cmd,
    output pes_pkg::t_dp_status                      o_status,
    input  wire logic [pes_pkg::OpW-1:0]             i_action,
    input  wire logic signed [pes_pkg::DataW-1:0]    i_dest_value,
    input  wire logic signed [pes_pkg::DataW-1:0]    i_first_operand,
    input  wire logic signed [pes_pkg::DataW-1:0]    i_second_operand,
    input  wire logic [pes_pkg::PcW-1:0]             i_next_pc,
    output logic signed [pes_pkg::DataW-1:0]         o_result,
    output logic                                     o_take_branch,
    output logic                                     o_stop_machine,
    output logic                                     o_bad_opcode,
    output logic                                     o_squashed
);

    logic signed [pes_pkg::DataW-1:0] r_result;
    logic                             r_take;
    logic                             r_stop;
    logic                             r_bad;
    logic                             r_squash;

    logic signed [pes_pkg::DataW-1:0] w_alu;
    logic                             w_take;
    logic                             w_stop;
    logic                             w_bad;
    logic                             w_lt;
    logic                             w_gt;
    logic                             w_nz;
    logic                             w_big_shift;
    logic [pes_pkg::ShamtW-1:0]       w_shamt;
    logic signed [pes_pkg::DataW-1:0] w_jump;
    logic signed [pes_pkg::DataW-1:0] w_quotient;
    logic                             w_div_done;

    pes_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_first_operand),
        .i_divisor  (i_second_operand),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign w_lt        = i_first_operand < i_second_operand;
    assign w_gt        = i_first_operand > i_second_operand;
    assign w_nz        = (i_second_operand != '0);
    assign w_big_shift = |i_second_operand[pes_pkg::DataW-1:pes_pkg::ShamtW];
    assign w_shamt     = i_second_operand[pes_pkg::ShamtW-1:0];
    assign w_jump      = $signed({1'b0, i_next_pc}) + i_dest_value;

    always_comb begin
        w_alu  = '0;
        w_take = 1'b0;
        w_stop = 1'b0;
        w_bad  = 1'b0;
        case (i_action)
            pes_pkg::OP_NOP:  w_alu = '0;
            pes_pkg::OP_ADD,
            pes_pkg::OP_LD,
            pes_pkg::OP_ST:   w_alu = i_first_operand + i_second_operand;
            pes_pkg::OP_MUL:  w_alu = i_first_operand * i_second_operand;
            pes_pkg::OP_SUB:  w_alu = i_first_operand - i_second_operand;
            pes_pkg::OP_DIV:  w_alu = '0;
            pes_pkg::OP_LSH:  w_alu = w_big_shift ? '0 : (i_first_operand <<< w_shamt);
            pes_pkg::OP_RSH: begin
                if (w_big_shift) begin
                    w_alu = {pes_pkg::DataW{i_first_operand[pes_pkg::DataW-1]}};
                end else begin
                    w_alu = i_first_operand >>> w_shamt;
                end
            end
            pes_pkg::OP_AND:  w_alu = i_first_operand & i_second_operand;
            pes_pkg::OP_OR:   w_alu = i_first_operand | i_second_operand;
            pes_pkg::OP_XOR:  w_alu = i_first_operand ^ i_second_operand;
            pes_pkg::OP_LDC,
            pes_pkg::OP_STC:  w_alu = i_second_operand;
            pes_pkg::OP_BLT: begin
                w_take = w_lt;
                w_alu  = i_dest_value;
            end
            pes_pkg::OP_BNZ: begin
                w_take = w_nz;
                w_alu  = i_dest_value;
            end
            pes_pkg::OP_B: begin
                w_take = 1'b1;
                w_alu  = i_dest_value;
            end
            pes_pkg::OP_J: begin
                w_take = 1'b1;
                w_alu  = w_jump;
            end
            pes_pkg::OP_JLT: begin
                w_take = w_lt;
                w_alu  = w_jump;
            end
            pes_pkg::OP_JNZ: begin
                w_take = w_nz;
                w_alu  = w_jump;
            end
            pes_pkg::OP_CMP:  w_alu = w_lt ? -32'sd1 : (w_gt ? 32'sd1 : 32'sd0);
            pes_pkg::OP_HALT: w_stop = 1'b1;
            default:          w_bad = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.squash) begin
                r_result <= '0;
                r_take   <= 1'b0;
                r_stop   <= 1'b0;
                r_bad    <= 1'b0;
                r_squash <= 1'b1;
            end else if (i_cmd.sel_div) begin
                r_result <= w_quotient;
                r_take   <= 1'b0;
                r_stop   <= 1'b0;
                r_bad    <= 1'b0;
                r_squash <= 1'b0;
            end else begin
                r_result <= w_alu;
                r_take   <= w_take;
                r_stop   <= w_stop;
                r_bad    <= w_bad;
                r_squash <= 1'b0;
            end
        end
    end

    assign o_status.take     = w_take;
    assign o_status.is_div   = (i_action == pes_pkg::OP_DIV);
    assign o_status.div_done = w_div_done;

    assign o_result       = r_result;
    assign o_take_branch  = r_take;
    assign o_stop_machine = r_stop;
    assign o_bad_opcode   = r_bad;
    assign o_squashed     = r_squash;

endmodule

`default_nettype wire

// ===== rtl/core/pes_ctrl.sv =====
`default_nettype none

module pes_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire pes_pkg::t_dp_status   i_status,
    output pes_pkg::t_dp_cmd           o_cmd
);

    pes_pkg::t_state r_state;
    pes_pkg::t_state n_state;
    logic            r_pending;
    logic            n_pending;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_accept;

    assign o_in_ready  = (r_state == pes_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            pes_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (r_pending) begin
                        // item behind a taken branch: flush it
                        o_cmd.load_out = 1'b1;
                        o_cmd.squash   = 1'b1;
                        n_pending      = 1'b0;
                        n_out_valid    = 1'b1;
                    end else if (i_status.is_div) begin
                        o_cmd.div_start = 1'b1;
                        n_pending       = 1'b0;
                        n_state         = pes_pkg::ST_DIV;
                    end else begin
                        o_cmd.load_out = 1'b1;
                        n_pending      = i_status.take;
                        n_out_valid    = 1'b1;
                    end
                end
            end
            pes_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.sel_div  = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = pes_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pes_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pes_pkg::ST_IDLE;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pipeline_execute_stage.sv =====
// Execute stage: takes one decoded instruction per request and returns one result
// per request, in order. Every opcode but DIV is computed in the accept cycle and
// lands in the output register, so those requests run at one per clock as long as
// the result side keeps up. DIV runs on a radix-2 restoring divider, one quotient
// bit per cycle: the quotient lands in the output register after the last bit and
// the input side is held off until then; the next request is taken once the result
// side is ready. A taken branch or jump flushes the next request: it returns
// squashed with all other fields zero and is not executed.
`default_nettype none

`include "pipeline_execute_stage_defines.svh"

module pipeline_execute_stage (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [pes_pkg::OpW-1:0]             i_action,
    input  wire logic signed [pes_pkg::DataW-1:0]    i_dest_value,
    input  wire logic signed [pes_pkg::DataW-1:0]    i_first_operand,
    input  wire logic signed [pes_pkg::DataW-1:0]    i_second_operand,
    input  wire logic [pes_pkg::PcW-1:0]             i_next_pc,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [pes_pkg::DataW-1:0]         o_result,
    output logic                                     o_take_branch,
    output logic                                     o_stop_machine,
    output logic                                     o_bad_opcode,
    output logic                                     o_squashed
);

    pes_pkg::t_dp_cmd    w_cmd;
    pes_pkg::t_dp_status w_status;

    pes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pes_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_action         (i_action),
        .i_dest_value     (i_dest_value),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_next_pc        (i_next_pc),
        .o_result         (o_result),
        .o_take_branch    (o_take_branch),
        .o_stop_machine   (o_stop_machine),
        .o_bad_opcode     (o_bad_opcode),
        .o_squashed       (o_squashed)
    );

    `PES_ASSERT_IMP(a_squash_clean, i_clk, i_rst_n, o_out_valid && o_squashed, o_result == '0 && !o_take_branch && !o_stop_machine && !o_bad_opcode, "squashed result not clean")
    `PES_ASSERT_NXT(a_div_stalls, i_clk, i_rst_n, w_cmd.div_start, !o_in_ready, "input taken during divide")
    `PES_ASSERT_IMP(a_div_out_free, i_clk, i_rst_n, w_status.div_done, !o_out_valid, "quotient ready while output busy")
    `PES_ASSERT_IMP(a_one_load, i_clk, i_rst_n, w_cmd.load_out, !w_cmd.div_start, "output load and divide start together")

endmodule

`default_nettype wire
